[sv/igf_pkg.sv]
// Shared widths and helpers for the inverse-square gravity force pipeline.
package igf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW    = 32;   // coordinate and force width
  localparam int DW    = 33;   // difference / magnitude width
  localparam int SQW   = 66;   // squared length width
  localparam int PW    = 65;   // |d| * |strength| width
  localparam int RTW   = 33;   // integer square root width
  localparam int SPLIT = 22;   // slice of len2 per partial product
  localparam int PPW   = SPLIT + RTW;
  localparam int DENW  = SQW + RTW;
  localparam int QW    = 33;   // quotient bits kept after the overflow check
  localparam int RMW   = DENW + QW;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic degen;
    logic last;
  } igf_flags_t;

  // Clip a quotient to the signed range and apply the sign.
  function automatic logic [CW:0] sat_comp(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QW-1:0] lim;
    logic          sat;
    logic [QW-1:0] mag;
    logic [QW-1:0] res;
    lim = neg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    sat = ovf || (q > lim);
    mag = sat ? lim : q;
    res = neg ? (QW'(0) - mag) : mag;
    return {sat, res[CW-1:0]};
  endfunction

endpackage

[sv/inverse_square_gravity_force.sv]
// Top level: 2D inverse-square force, d * strength / |d|^3, fully pipelined.
//
// One request (entity/generator pair) enters per cycle and one result leaves per cycle
// while the output is not stalled; the depth is set by the bit-per-stage square root
// (33 stages) and the bit-per-stage divider (34 stages, overflow check plus 33 quotient
// bits). All stages advance together whenever the output register is empty or being
// taken, so in_tready follows out_tready within the cycle; a stall holds every stage
// and loses nothing. Forces are signed fixed point with FRAC_BITS fraction bits, cut
// toward zero and clipped to 32 bits; an invalid pair or zero distance gives zero force
// with the degenerate flag.
module inverse_square_gravity_force #(
  parameter int FRAC_BITS = igf_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // entity_x, entity_y, source_x, source_y, source_strength
  input  logic [0:0]   in_tuser,   // pair_valid
  input  logic         in_tlast,   // batch_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // force_x, force_y
  output logic [1:0]   out_tuser,  // degenerate, saturated
  output logic         out_tlast   // batch_last_out
);

  localparam int CW    = igf_pkg::CW;
  localparam int DW    = igf_pkg::DW;
  localparam int SQW   = igf_pkg::SQW;
  localparam int PW    = igf_pkg::PW;
  localparam int RTW   = igf_pkg::RTW;
  localparam int SPLIT = igf_pkg::SPLIT;
  localparam int PPW   = igf_pkg::PPW;
  localparam int DENW  = igf_pkg::DENW;
  localparam int QW    = igf_pkg::QW;
  localparam int NW    = PW + 2 * FRAC_BITS;
  localparam int FW    = $bits(igf_pkg::igf_flags_t);
  localparam int SBW   = 2 * PW + SQW + FW;

  logic en;

  // Advance the whole pipe when the output slot is free or being taken.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: differences, magnitudes, signs, degenerate check.
  logic [CW-1:0] ex, ey, sx, sy, st;
  logic [DW-1:0] dx, dy, adx, ady, ast;
  igf_pkg::igf_flags_t f1_nxt;

  assign ex = in_tdata[31:0];
  assign ey = in_tdata[63:32];
  assign sx = in_tdata[95:64];
  assign sy = in_tdata[127:96];
  assign st = in_tdata[159:128];

  always_comb begin
    dx  = {ex[CW-1], ex} - {sx[CW-1], sx};
    dy  = {ey[CW-1], ey} - {sy[CW-1], sy};
    adx = dx[DW-1] ? (DW'(0) - dx) : dx;
    ady = dy[DW-1] ? (DW'(0) - dy) : dy;
    ast = st[CW-1] ? (DW'(0) - {st[CW-1], st}) : {1'b0, st};
    f1_nxt.neg_x = dx[DW-1] ^ st[CW-1];
    f1_nxt.neg_y = dy[DW-1] ^ st[CW-1];
    f1_nxt.degen = !in_tuser[0] || ((dx == '0) && (dy == '0));
    f1_nxt.last  = in_tlast;
  end

  logic                v1_r;
  logic [DW-1:0]       adx_r, ady_r;
  logic [CW-1:0]       as_r;
  igf_pkg::igf_flags_t f1_r;

  // Stage 2: squares and numerator products.
  logic                v2_r;
  logic [SQW-1:0]      sqx_r, sqy_r;
  logic [PW-1:0]       px2_r, py2_r;
  igf_pkg::igf_flags_t f2_r;

  // Stage 3: squared length.
  logic                v3_r;
  logic [SQW-1:0]      len2_r;
  logic [PW-1:0]       px3_r, py3_r;
  igf_pkg::igf_flags_t f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r  <= adx;
      ady_r  <= ady;
      as_r   <= ast[CW-1:0];
      f1_r   <= f1_nxt;
      sqx_r  <= SQW'(adx_r) * SQW'(adx_r);
      sqy_r  <= SQW'(ady_r) * SQW'(ady_r);
      px2_r  <= PW'(adx_r) * PW'(as_r);
      py2_r  <= PW'(ady_r) * PW'(as_r);
      f2_r   <= f1_r;
      len2_r <= sqx_r + sqy_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      f3_r   <= f2_r;
    end
  end

  // Square root of the squared length, products riding alongside.
  logic            vs;
  logic [RTW-1:0]  root;
  logic [SBW-1:0]  sbs;
  logic [PW-1:0]   pxs, pys;
  logic [SQW-1:0]  len2s;
  igf_pkg::igf_flags_t fs;

  igf_sqrt #(.SBW(SBW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_val   (len2_r),
    .in_sb    ({px3_r, py3_r, len2_r, f3_r}),
    .out_vld  (vs),
    .out_root (root),
    .out_sb   (sbs)
  );

  assign {pxs, pys, len2s, fs} = sbs;

  // Stage 4: len2 * root in three partial products; scale numerators.
  logic                v4_r;
  logic [PPW-1:0]      pp0_r, pp1_r, pp2_r;
  logic [NW-1:0]       nx4_r, ny4_r;
  igf_pkg::igf_flags_t f4_r;

  // Stage 5: sum partials into the denominator.
  logic                v5_r;
  logic [DENW-1:0]     den_r;
  logic [NW-1:0]       nx5_r, ny5_r;
  igf_pkg::igf_flags_t f5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= vs;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r <= PPW'(len2s[SPLIT-1:0]) * PPW'(root);
      pp1_r <= PPW'(len2s[2*SPLIT-1:SPLIT]) * PPW'(root);
      pp2_r <= PPW'(len2s[SQW-1:2*SPLIT]) * PPW'(root);
      nx4_r <= NW'(pxs) << (2 * FRAC_BITS);
      ny4_r <= NW'(pys) << (2 * FRAC_BITS);
      f4_r  <= fs;
      den_r <= DENW'(pp0_r) + (DENW'(pp1_r) << SPLIT) + (DENW'(pp2_r) << (2 * SPLIT));
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
      f5_r  <= f4_r;
    end
  end

  // Divide both numerators by the shared denominator.
  logic                vd;
  logic [QW-1:0]       qx, qy;
  logic                ovx, ovy;
  igf_pkg::igf_flags_t fd;

  igf_div #(.NW(NW), .SBW(FW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v5_r),
    .num_x   (nx5_r),
    .num_y   (ny5_r),
    .den     (den_r),
    .in_sb   (f5_r),
    .out_vld (vd),
    .q_x     (qx),
    .q_y     (qy),
    .ovf_x   (ovx),
    .ovf_y   (ovy),
    .out_sb  (fd)
  );

  // Output stage: clip, sign, drop degenerate pairs to zero.
  logic [CW:0]   cx, cy;
  logic [CW-1:0] fx_nxt, fy_nxt;
  logic          sat_nxt;

  always_comb begin
    cx      = igf_pkg::sat_comp(qx, ovx, fd.neg_x);
    cy      = igf_pkg::sat_comp(qy, ovy, fd.neg_y);
    fx_nxt  = fd.degen ? '0 : cx[CW-1:0];
    fy_nxt  = fd.degen ? '0 : cy[CW-1:0];
    sat_nxt = !fd.degen && (cx[CW] || cy[CW]);
  end

  logic          ovld_r;
  logic [CW-1:0] fx_r, fy_r;
  logic          deg_r, sat_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r   <= fx_nxt;
      fy_r   <= fy_nxt;
      deg_r  <= fd.degen;
      sat_r  <= sat_nxt;
      last_r <= fd.last;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {fy_r, fx_r};
  assign out_tuser  = {sat_r, deg_r};
  assign out_tlast  = last_r;

  // A degenerate result carries zero force and no clip flag.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1])
    else $error("degenerate result with nonzero force or clip flag");

  // The input side is held exactly when a finished result waits.
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready out of step with output stall");

  // Nothing comes out the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

[sv/igf_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband.
module igf_sqrt #(
  parameter int SBW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [igf_pkg::SQW-1:0] in_val,
  input  logic [SBW-1:0]          in_sb,
  output logic                    out_vld,
  output logic [igf_pkg::RTW-1:0] out_root,
  output logic [SBW-1:0]          out_sb
);

  localparam int SQW = igf_pkg::SQW;
  localparam int RTW = igf_pkg::RTW;

  logic             vld_r  [RTW];
  logic [SQW-1:0]   rem_r  [RTW];
  logic [RTW-1:0]   root_r [RTW];
  logic [SBW-1:0]   sb_r   [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    localparam int B = RTW - 1 - k;
    logic           v_in;
    logic [SQW-1:0] rem_in;
    logic [RTW-1:0] root_in;
    logic [SBW-1:0] sb_in;
    logic [SQW:0]   trial;
    logic           take;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign trial = ({{(SQW+1-RTW){1'b0}}, root_in} << (B + 1))
                 + ((SQW+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (rem_in - trial[SQW-1:0]) : rem_in;
        root_r[k] <= take ? (root_in | (RTW'(1) << B)) : root_in;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[RTW-1];
  assign out_root = root_r[RTW-1];
  assign out_sb   = sb_r[RTW-1];

endmodule

[sv/igf_div.sv]
// Pipelined restoring divider, two numerators over one denominator.
module igf_div #(
  parameter int NW  = 97,
  parameter int SBW = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [NW-1:0]            num_x,
  input  logic [NW-1:0]            num_y,
  input  logic [igf_pkg::DENW-1:0] den,
  input  logic [SBW-1:0]           in_sb,
  output logic                     out_vld,
  output logic [igf_pkg::QW-1:0]   q_x,
  output logic [igf_pkg::QW-1:0]   q_y,
  output logic                     ovf_x,
  output logic                     ovf_y,
  output logic [SBW-1:0]           out_sb
);

  localparam int QW   = igf_pkg::QW;
  localparam int DENW = igf_pkg::DENW;
  localparam int RMW  = (NW > igf_pkg::RMW) ? NW : igf_pkg::RMW;

  logic            vld_r  [QW+1];
  logic [RMW-1:0]  remx_r [QW+1];
  logic [RMW-1:0]  remy_r [QW+1];
  logic [QW-1:0]   qx_r   [QW+1];
  logic [QW-1:0]   qy_r   [QW+1];
  logic            ovx_r  [QW+1];
  logic            ovy_r  [QW+1];
  logic [DENW-1:0] den_r  [QW+1];
  logic [SBW-1:0]  sb_r   [QW+1];

  for (genvar k = 0; k <= QW; k++) begin : g_stage
    logic           v_in;
    logic [RMW-1:0] rx_in, ry_in, dsh;
    logic [QW-1:0]  qx_in, qy_in;
    logic           ox_in, oy_in;
    logic [DENW-1:0] d_in;
    logic [SBW-1:0] sb_in;
    logic [RMW-1:0] rx_nxt, ry_nxt;
    logic [QW-1:0]  qx_nxt, qy_nxt;
    logic           ox_nxt, oy_nxt;

    if (k == 0) begin : g_first
      // Flag quotients of 2^QW and above up front.
      assign v_in  = in_vld;
      assign rx_in = RMW'(num_x);
      assign ry_in = RMW'(num_y);
      assign qx_in = '0;
      assign qy_in = '0;
      assign ox_in = 1'b0;
      assign oy_in = 1'b0;
      assign d_in  = den;
      assign sb_in = in_sb;
      assign dsh   = RMW'(den) << QW;
      assign rx_nxt = rx_in;
      assign ry_nxt = ry_in;
      assign qx_nxt = qx_in;
      assign qy_nxt = qy_in;
      assign ox_nxt = rx_in >= dsh;
      assign oy_nxt = ry_in >= dsh;
    end else begin : g_next
      localparam int I = QW - k;
      logic tx, ty;
      assign v_in  = vld_r[k-1];
      assign rx_in = remx_r[k-1];
      assign ry_in = remy_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
      assign ox_in = ovx_r[k-1];
      assign oy_in = ovy_r[k-1];
      assign d_in  = den_r[k-1];
      assign sb_in = sb_r[k-1];
      assign dsh   = RMW'(d_in) << I;
      assign tx    = rx_in >= dsh;
      assign ty    = ry_in >= dsh;
      assign rx_nxt = tx ? (rx_in - dsh) : rx_in;
      assign ry_nxt = ty ? (ry_in - dsh) : ry_in;
      assign qx_nxt = tx ? (qx_in | (QW'(1) << I)) : qx_in;
      assign qy_nxt = ty ? (qy_in | (QW'(1) << I)) : qy_in;
      assign ox_nxt = ox_in;
      assign oy_nxt = oy_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k] <= rx_nxt;
        remy_r[k] <= ry_nxt;
        qx_r[k]   <= qx_nxt;
        qy_r[k]   <= qy_nxt;
        ovx_r[k]  <= ox_nxt;
        ovy_r[k]  <= oy_nxt;
        den_r[k]  <= d_in;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign q_x     = qx_r[QW];
  assign q_y     = qy_r[QW];
  assign ovf_x   = ovx_r[QW];
  assign ovf_y   = ovy_r[QW];
  assign out_sb  = sb_r[QW];

endmodule

[tb/inverse_square_gravity_force_test.sv]
// Testbench for the inverse-square gravity force pipeline: scoreboard class and stimulus.
module inverse_square_gravity_force_test;

  localparam int FB = igf_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 73;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic        degenerate;
    logic        saturated;
    logic        last;
  } force_t;

  // Predict and check the force of each accepted pair.
  class force_scoreboard;
    force_t pending_forces[$];
    int     mismatches;

    // Exact component: |c| * |s| * 2^(2*FB) / (len2 * root), then sign and clip.
    function automatic logic [31:0] component(input logic signed [32:0] c,
                                              input logic signed [31:0] s,
                                              input logic [65:0] len2,
                                              input logic [32:0] root,
                                              inout logic sat);
      logic [32:0]  ac;
      logic [32:0]  as_;
      logic         neg;
      logic [191:0] num;
      logic [191:0] den;
      logic [191:0] q;
      logic [31:0]  lim;
      logic [31:0]  mag;
      ac = c[32] ? 33'(-c) : 33'(c);
      as_ = s[31] ? 33'(-{s[31], s}) : 33'({1'b0, s});
      neg = c[32] != s[31];
      if (ac == 0 || as_ == 0) return 32'd0;
      num = (192'(ac) * 192'(as_)) << (2 * FB);
      den = 192'(len2) * 192'(root);
      q = num / den;
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (q > 192'(lim)) begin
        mag = lim;
        sat = 1'b1;
      end else begin
        mag = q[31:0];
      end
      return neg ? -mag : mag;
    endfunction

    function automatic logic [32:0] isqrt(input logic [65:0] v);
      logic [32:0] r;
      logic [32:0] cand;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        cand = r | (33'd1 << b);
        if (66'(cand) * 66'(cand) <= v) r = cand;
      end
      return r;
    endfunction

    // Note an accepted pair: compute and queue its expected force.
    function void note_pair(input logic [159:0] data, input logic valid, input logic last);
      force_t e;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [32:0] adx;
      logic [32:0] ady;
      logic [65:0] len2;
      logic [32:0] root;
      logic sat;
      dx = $signed(data[31:0]) - $signed(data[95:64]);
      dy = $signed(data[63:32]) - $signed(data[127:96]);
      e = '0;
      e.last = last;
      sat = 1'b0;
      if (!valid || (dx == 0 && dy == 0)) begin
        e.degenerate = 1'b1;
      end else begin
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
        len2 = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        root = isqrt(len2);
        e.force_x = component(dx, data[159:128], len2, root, sat);
        e.force_y = component(dy, data[159:128], len2, root, sat);
        e.saturated = sat;
      end
      pending_forces.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation.
    task check_result(input force_t got);
      force_t e;
      if (pending_forces.size() == 0) begin
        report("result with no pair waiting");
        return;
      end
      e = pending_forces.pop_front();
      if (got.force_x !== e.force_x)
        report($sformatf("force_x got %h want %h", got.force_x, e.force_x));
      if (got.force_y !== e.force_y)
        report($sformatf("force_y got %h want %h", got.force_y, e.force_y));
      if (got.degenerate !== e.degenerate) report("degenerate flag mismatch");
      if (got.saturated !== e.saturated) report("saturated flag mismatch");
      if (got.last !== e.last) report("last flag mismatch");
    endtask

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;   // entity_x, entity_y, source_x, source_y, source_strength
  logic [0:0]   in_tuser;   // pair_valid
  logic         in_tlast;   // batch_last
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // force_x, force_y
  logic [1:0]   out_tuser;  // degenerate, saturated
  logic         out_tlast;  // batch_last_out

  force_scoreboard board;
  int  cycles;

  inverse_square_gravity_force dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample results at the rising edge; end the run on a timeout.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_tvalid && out_tready)
      board.check_result('{out_tdata[31:0], out_tdata[63:32], out_tuser[0], out_tuser[1],
                           out_tlast});
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result side in phases: free runs, occasional stalls, stalls about half the time.
  initial begin
    int mode;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      mode = (cycles / 500) % 3;
      if (mode == 0) out_tready <= 1'b1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 1) != 0);
    end
  end

  // Hold a request until the block takes it.
  task automatic send_pair(input logic [159:0] data, input logic valid, input logic last);
    in_tdata <= data;
    in_tuser <= valid;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    board.note_pair(data, valid, last);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) - 128;
      3: return ($urandom_range(0, 8191) - 4096) << FB;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [31:0] ex, ey, sx, sy, st;
    int burst;
    int gap;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        ex = rand_word();
        ey = rand_word();
        sx = $urandom_range(0, 9) == 0 ? ex : rand_word();
        sy = $urandom_range(0, 9) == 0 ? ey : rand_word();
        if ($urandom_range(0, 3) == 0) begin
          // Nearby pair so the force stays in range.
          sx = ex + $urandom_range(0, 1 << 20) - (1 << 19);
          sy = ey + $urandom_range(0, 1 << 20) - (1 << 19);
        end
        st = $urandom_range(0, 15) == 0 ? 32'd0 : rand_word();
        send_pair({st, sy, sx, ey, ex}, $urandom_range(0, 7) != 0,
                  1'($urandom_range(0, 1)));
        burst--;
        n--;
      end
      // Drop valid for a random gap between bursts, sometimes none.
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      if (gap > 0 && n > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: invalid pair, zero distance, clipping both signs, zero strength and axis.
    send_pair({32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1'b0, 1'b0);
    send_pair({32'h0001_0000, 32'd5, 32'd5, 32'd5, 32'd5}, 1'b1, 1'b1);
    send_pair({32'h7FFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd1}, 1'b1, 1'b0);
    send_pair({32'h8000_0000, 32'd0, 32'd0, 32'd1, 32'd1}, 1'b1, 1'b0);
    send_pair({32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'h8000_0000}, 1'b1, 1'b1);
    send_pair({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
              1'b1, 1'b0);
    send_pair({32'd0, 32'd3, 32'd4, 32'd0, 32'd0}, 1'b1, 1'b0);
    send_pair({32'h0001_0000, 32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000}, 1'b1, 1'b1);
    send_pair({32'hFFFF_0000, 32'd0, 32'd0, 32'h0000_0000, 32'h0002_0000}, 1'b1, 1'b0);
    send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
              1'b1, 1'b1);
    send_pair({32'h0000_0080, 32'd0, 32'd0, 32'd0, 32'h0000_0001}, 1'b1, 1'b0);
    send_pair({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h0000_0100}, 1'b1, 1'b0);
    in_tvalid <= 1'b0;
    repeat (3) @(negedge clk);

    send_random(400);
    in_tvalid <= 1'b0;

    while (board.pending_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_forces.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
